// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants shared by the piecewise linear interpolator files.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DATA_W = 32;
  localparam int NUM_W  = 2 * DATA_W;
  localparam int DEN_W  = DATA_W;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;
  localparam logic [1:0] ST_FLAT   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDL,
    S_CHK,
    S_SCAN,
    S_FAR,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_OUT
  } pli_state_t;

endpackage

// ===== src/piecewise_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table with linear interpolation and end-segment extrapolation.
// ----------------------------------------------------------------------------
// A load (action 0) writes one breakpoint in the clock it is taken and leaves
// busy low, so loads may follow each other every cycle. A query (action 1)
// holds busy high while a small sequencer reads the table one point per cycle
// from a RAM with one write and one read port, then runs one 32x32 multiply
// and, unless the segment has zero width, a 64-step serial divider. A query
// that hits the first x answers straight from the end-point check; one that
// extrapolates reads point 1 or the next-to-last point without a scan, and one
// that interpolates first scans up to the upper bracketing point. The result
// shows for exactly one cycle with done high and is not held, so the receiver
// must take it then. Write point_count only while busy is low.
module piecewise_linear_interpolator_top
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  output logic               done,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [35:0] SUM_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] SUM_MIN = -36'sh080000000;

  pli_state_t state, state_next;

  logic [6:0]    point_count;
  logic [CW-1:0] n_use;
  logic [AW-1:0] last_idx, pen_idx;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [2*DATA_W-1:0]   ram_rdata;
  logic signed [31:0]    rd_x, rd_y;

  logic signed [31:0] xq, ax, ay, bx, by;
  logic [AW-1:0]      idx;
  logic [1:0]         stat;
  logic [DEN_W-1:0]   ux, mdy, mt;
  logic               neg, flat;
  logic [NUM_W-1:0]   num;
  logic [NUM_W:0]     qr;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_q;
  logic [DEN_W-1:0]   div_r;

  logic accept, query_go, below, above, direct, scan_stop;
  logic signed [32:0] dx, dy, dt;
  logic signed [35:0] qs, sum;

  // ---------------- configuration and table ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 7'd2;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  always_comb begin
    if (point_count < 7'd2) begin
      n_use = CW'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_use = CW'(MAX_POINTS);
    end else begin
      n_use = CW'(point_count);
    end
  end

  assign last_idx = AW'(n_use - CW'(1));
  assign pen_idx  = AW'(n_use - CW'(2));

  assign accept   = start && !busy;
  assign query_go = accept && (action == ACT_QUERY);
  assign ram_we   = accept && (action == ACT_LOAD) && (int'(point_index) < MAX_POINTS);

  pli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata ({point_x, point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[2*DATA_W-1:DATA_W];
  assign rd_y = ram_rdata[DATA_W-1:0];

  // ---------------- decisions ----------------
  // in S_CHK ax holds point 0 and the RAM shows the last point
  assign below     = xq < ax;
  assign above     = xq > rd_x;
  assign direct    = !below && !above && (ax >= xq);
  assign scan_stop = (idx == last_idx) || (rd_x >= xq);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (query_go) state_next = S_RDL;
      S_RDL:   state_next = S_CHK;
      S_CHK: begin
        if (below || above) begin
          state_next = S_FAR;
        end else if (direct) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN:  if (scan_stop) state_next = S_SETUP;
      S_FAR:   state_next = S_SETUP;
      S_SETUP: state_next = S_MUL;
      S_MUL:   state_next = flat ? S_OUT : S_DIV;
      S_DIV:   state_next = S_WAIT;
      S_WAIT:  if (div_done) state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr = '0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:  ram_raddr = '0;
      S_RDL:   ram_raddr = last_idx;
      // below wins over above on an unsorted table
      S_CHK:   ram_raddr = (above && !below) ? pen_idx : AW'(1);
      S_SCAN:  ram_raddr = idx + AW'(1);
      S_DIV:   div_start = 1'b1;
      default: ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // ---------------- datapath ----------------
  assign dx = 33'(bx) - 33'(ax);
  assign dy = 33'(by) - 33'(ay);
  assign dt = 33'(xq) - 33'(ax);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: xq <= query_x;
      S_RDL: begin
        ax <= rd_x;
        ay <= rd_y;
      end
      S_CHK: begin
        idx <= AW'(1);
        if (below) begin
          stat <= ST_BELOW;
        end else if (above) begin
          stat <= ST_ABOVE;
          ax   <= rd_x;
          ay   <= rd_y;
        end else begin
          stat <= ST_INTERP;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          bx <= rd_x;
          by <= rd_y;
        end else begin
          ax  <= rd_x;
          ay  <= rd_y;
          idx <= idx + AW'(1);
        end
      end
      S_FAR: begin
        bx <= rd_x;
        by <= rd_y;
      end
      S_SETUP: begin
        flat <= (dx == '0);
        neg  <= ((dy < 0) != (dt < 0)) != (dx < 0);
        ux   <= (dx < 0) ? DEN_W'(-dx) : DEN_W'(dx);
        mdy  <= (dy < 0) ? DEN_W'(-dy) : DEN_W'(dy);
        mt   <= (dt < 0) ? DEN_W'(-dt) : DEN_W'(dt);
      end
      S_MUL: num <= mdy * mt;
      S_WAIT: begin
        // round half away from zero on the magnitude
        if (div_done) begin
          qr <= {1'b0, div_q} + (NUM_W + 1)'({div_r, 1'b0} >= {1'b0, ux});
        end
      end
      default: ;
    endcase
  end

  pli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (num),
    .divisor   (ux),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign qs  = {2'b00, qr[33:0]};
  assign sum = 36'(ay) + (neg ? -qs : qs);

  // ---------------- result beat ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == S_CHK) && direct) || (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && direct) begin
      value     <= ay;
      status    <= ST_INTERP;
      saturated <= 1'b0;
    end else if (state == S_OUT) begin
      if (flat) begin
        value     <= '0;
        status    <= ST_FLAT;
        saturated <= 1'b0;
      end else begin
        status <= stat;
        if (|qr[NUM_W:34]) begin
          value     <= neg ? VAL_MIN : VAL_MAX;
          saturated <= 1'b1;
        end else if (sum > SUM_MAX) begin
          value     <= VAL_MAX;
          saturated <= 1'b1;
        end else if (sum < SUM_MIN) begin
          value     <= VAL_MIN;
          saturated <= 1'b1;
        end else begin
          value     <= sum[31:0];
          saturated <= 1'b0;
        end
      end
    end
  end

  // ---------------- checks ----------------
  a_done_in_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result beat while a query is still running");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_go |=> busy)
    else $error("query accepted but busy not raised");

  a_flat_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FLAT) |-> (value == '0 && !saturated))
    else $error("zero-width segment result not cleared");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (value == VAL_MAX || value == VAL_MIN))
    else $error("saturated result not at a rail");

  a_div_only_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

endmodule

// ===== src/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pli_div.sv =====
// ----------------------------------------------------------------------------
// pli_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div
  import pli_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign shifted = {remainder, quotient[NUM_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient  <= dividend;
      remainder <= '0;
      den       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[NUM_W-2:0], ge};
      remainder <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

// ===== tb/piecewise_linear_interpolator_top_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top_tb
// Loads breakpoint tables, sweeps point_count and queries the interpolator;
// every answer is checked against a cycle-free predictor kept in step with
// each accepted beat.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top_tb
  import pli_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 64;
  localparam int CLK_HALF     = 10;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_BEATS  = 500;
  localparam logic signed [31:0] X_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] X_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               saturated;
  } interp_result_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               action      = ACT_LOAD;
  logic [5:0]         point_index = '0;
  logic signed [31:0] point_x     = '0;
  logic signed [31:0] point_y     = '0;
  logic signed [31:0] query_x     = '0;
  logic               cfg_we      = 1'b0;
  logic [6:0]         cfg_data    = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic               saturated;

  piecewise_linear_interpolator_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .query_x     (query_x),
    .done        (done),
    .value       (value),
    .status      (status),
    .saturated   (saturated),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // mirror of the breakpoint table and the count register
  logic signed [31:0] knot_x [TABLE_DEPTH];
  logic signed [31:0] knot_y [TABLE_DEPTH];
  logic [6:0]         knot_count;
  interp_result_t     interp_due [$];

  int          mismatch_count = 0;
  int          beat_count     = 0;
  int          gap_pct        = 0;
  int unsigned cycle_count    = 0;

  function automatic int active_points();
    if (knot_count < 2) return 2;
    if (knot_count > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(knot_count);
  endfunction

  function automatic interp_result_t interp_at(input logic signed [31:0] xq);
    interp_result_t res;
    int n, i, ia, ib;
    longint xa, ya, xb, yb, dx, dy, t, sum;
    logic [63:0] ux, mag_dy, mag_t, num, q, r;
    logic neg;
    n = active_points();
    res = '0;
    if (xq < knot_x[0]) begin
      ia = 0;
      ib = 1;
      res.status = ST_BELOW;
    end else if (xq > knot_x[n-1]) begin
      ia = n - 1;
      ib = n - 2;
      res.status = ST_ABOVE;
    end else begin
      i = 0;
      while (i < n - 1 && knot_x[i] < xq) i++;
      res.status = ST_INTERP;
      if (i == 0) begin
        res.value = knot_y[0];
        return res;
      end
      ia = i - 1;
      ib = i;
    end
    xa = longint'(knot_x[ia]);
    ya = longint'(knot_y[ia]);
    xb = longint'(knot_x[ib]);
    yb = longint'(knot_y[ib]);
    dx = xb - xa;
    dy = yb - ya;
    t  = longint'(xq) - xa;
    if (dx == 0) begin
      res.value  = '0;
      res.status = ST_FLAT;
      return res;
    end
    // sign-magnitude divide, ties rounded away from zero
    neg    = ((dy < 0) != (t < 0)) != (dx < 0);
    ux     = (dx < 0) ? -dx : dx;
    mag_dy = (dy < 0) ? -dy : dy;
    mag_t  = (t < 0) ? -t : t;
    num    = mag_dy * mag_t;
    q      = num / ux;
    r      = num % ux;
    if ((r << 1) >= ux) q = q + 1;
    if (q >= 64'h4_0000_0000) begin
      res.value     = neg ? X_MIN : X_MAX;
      res.saturated = 1'b1;
    end else begin
      sum = ya + (neg ? -longint'(q) : longint'(q));
      if (sum > longint'(X_MAX)) begin
        sum = longint'(X_MAX);
        res.saturated = 1'b1;
      end
      if (sum < longint'(X_MIN)) begin
        sum = longint'(X_MIN);
        res.saturated = 1'b1;
      end
      res.value = sum[31:0];
    end
    return res;
  endfunction

  task automatic send_beat(input logic act, input logic [5:0] idx,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] qx);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    action      <= act;
    point_index <= idx;
    point_x     <= px;
    point_y     <= py;
    query_x     <= qx;
    do @(posedge clk); while (busy);
    beat_count++;
    if (act == ACT_LOAD) begin
      knot_x[idx] = px;
      knot_y[idx] = py;
    end else begin
      interp_due.push_back(interp_at(qx));
    end
  endtask

  task automatic send_load(input int idx, input logic signed [31:0] px,
                           input logic signed [31:0] py);
    send_beat(ACT_LOAD, idx[5:0], px, py, $urandom);
  endtask

  task automatic send_query(input logic signed [31:0] qx);
    send_beat(ACT_QUERY, 6'($urandom_range(0, 63)), $urandom, $urandom, qx);
  endtask

  // hold off until every answer is in and the sequencer is back at rest
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (interp_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [6:0] cnt);
    wait_quiet();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cnt;
    @(negedge clk);
    cfg_we   <= 1'b0;
    knot_count = cnt;
  endtask

  task automatic build_table(input int n);
    logic signed [31:0] gx [TABLE_DEPTH];
    logic signed [31:0] gy [TABLE_DEPTH];
    int kind, shift, j;
    longint span, xpos, ypos;
    kind  = $urandom_range(0, 9);
    shift = $urandom_range(0, 25);
    span  = longint'(n) << shift;
    xpos  = longint'($urandom) % ((longint'(1) << 32) - span) - (longint'(1) << 31);
    ypos  = longint'($urandom) - (longint'(1) << 31);
    for (j = 0; j < n; j++) begin
      if (kind == 7) begin
        gx[j] = $urandom;
      end else begin
        gx[j] = xpos[31:0];
        xpos += longint'($urandom_range(0, 1 << shift));
      end
      if (kind == 8 || $urandom_range(0, 1) == 0) begin
        gy[j] = $urandom;
      end else begin
        gy[j] = ypos[31:0];
        ypos += longint'($urandom_range(0, 2 << shift)) - (longint'(1) << shift);
      end
    end
    // zero-width end segments, or a table where every x is the same
    if (kind == 6) begin
      if ($urandom_range(0, 1) == 1) gx[1] = gx[0];
      else gx[n-1] = gx[n-2];
    end
    if (kind == 9) begin
      for (j = 1; j < n; j++) gx[j] = gx[0];
    end
    if ($urandom_range(0, 1) == 1) begin
      for (j = 0; j < n; j++) send_load(j, gx[j], gy[j]);
    end else begin
      for (j = n - 1; j >= 0; j--) send_load(j, gx[j], gy[j]);
    end
  endtask

  function automatic logic signed [31:0] pick_query();
    int n, j;
    longint lo, hi, pick;
    n  = active_points();
    j  = $urandom_range(0, n - 1);
    lo = longint'(knot_x[0]);
    hi = longint'(knot_x[n-1]);
    case ($urandom_range(0, 9))
      0: pick = longint'($urandom);
      1: pick = longint'(knot_x[j]);
      2: pick = longint'(knot_x[j]) + (($urandom_range(0, 1) == 1) ? 1 : -1);
      3: pick = longint'(($urandom_range(0, 1) == 1) ? X_MAX : X_MIN);
      4: pick = lo;
      default: begin
        if (hi > lo) pick = lo + longint'($urandom) % (hi - lo + 1);
        else pick = lo - 1 + longint'($urandom_range(0, 2));
      end
    endcase
    return pick[31:0];
  endfunction

  function automatic logic [6:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 7'($urandom_range(0, 1));
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      default: return 7'($urandom_range(2, 12));
    endcase
  endfunction

  // fills every slot so no query ever reads an unwritten entry
  task automatic test_reset_count();
    int j;
    for (j = 0; j < TABLE_DEPTH; j++)
      send_load(j, (j - 32) * (1 << 24), (j * j - 1000) * (1 << 18));
    send_query(X_MIN);
    send_query(knot_x[0]);
    send_query(knot_x[0] + 32'sd8388608);
    send_query(knot_x[1]);
    send_query(32'sd0);
    send_query(X_MAX);
  endtask

  task automatic test_directed();
    set_point_count(7'd4);
    send_load(0, 32'sd0, 32'sd0);
    send_load(1, 32'sd2, 32'sd1);
    send_load(2, 32'sd4, 32'sd0);
    send_load(3, 32'sd10, X_MAX);
    send_query(32'sd0);   // hits first x
    send_query(32'sd1);   // half rounds up
    send_query(32'sd3);   // minus half rounds away from zero
    send_query(32'sd4);
    send_query(32'sd7);
    send_query(X_MIN);
    send_query(X_MAX);    // clips high
    send_load(3, 32'sd10, X_MIN);
    send_query(X_MAX);    // clips low
    send_load(1, 32'sd0, 32'sd5);
    send_query(-32'sd1);  // zero-width first segment
    send_load(2, 32'sd10, 32'sd7);
    send_query(32'sd11);  // zero-width last segment
    set_point_count(7'd2);
    send_load(0, X_MIN, X_MIN);
    send_load(1, X_MAX, X_MAX);
    send_query(32'sd0);
    send_query(-32'sd1);
    send_query(X_MIN);
    send_query(X_MAX);
  endtask

  task automatic test_count_range();
    logic [6:0] sweep [8];
    int k;
    sweep = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
    set_point_count(7'd64);
    build_table(TABLE_DEPTH);
    for (k = 0; k < 8; k++) begin
      set_point_count(sweep[k]);
      repeat (6) send_query(pick_query());
    end
  endtask

  task automatic test_random(input int pct, input int beats);
    int target;
    gap_pct = pct;
    target  = beat_count + beats;
    while (beat_count < target) begin
      if ($urandom_range(0, 2) == 0) set_point_count(pick_count());
      build_table(active_points());
      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 9) == 0) send_load($urandom_range(0, 63), $urandom, $urandom);
        else send_query(pick_query());
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    interp_result_t want;
    if (!rst && done) begin
      if (interp_due.size() == 0) begin
        $error("result with no query pending: value %0d status %0d", value, status);
        mismatch_count++;
      end else begin
        want = interp_due.pop_front();
        if (value !== want.value) begin
          $error("value mismatch: expected %0d, actual %0d", want.value, value);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0d, actual %0d", want.saturated, saturated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    knot_count = 7'd2;
    gap_pct    = 21;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_count();
    test_directed();
    test_count_range();
    test_random(21, PHASE_BEATS);
    test_random(52, PHASE_BEATS);
    test_random(0, PHASE_BEATS);
    wait_quiet();
    // room for a stray late beat
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
